FILE: src/ps2mct_pkg.sv
// ----------------------------------------------------------------------------
// ps2mct_pkg
// Shared widths, register indexes, status-byte masks and the packet phase
// type for the PS/2 mouse cursor tracker.
// ----------------------------------------------------------------------------
package ps2mct_pkg;

    localparam int BYTE_WIDTH      = 8;
    localparam int RES_WIDTH       = 12;
    localparam int COORD_WIDTH     = 12;
    localparam int STEP_WIDTH      = 10;
    localparam int CFG_INDEX_WIDTH = 2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_X_RESOLUTION = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_Y_RESOLUTION = 2'd1;

    // Resolution reset values
    localparam logic [RES_WIDTH-1:0] X_RESOLUTION_RESET = 12'd1023;
    localparam logic [RES_WIDTH-1:0] Y_RESOLUTION_RESET = 12'd767;

    // Status byte fields
    localparam logic [BYTE_WIDTH-1:0] STATUS_LEFT   = 8'h01;
    localparam logic [BYTE_WIDTH-1:0] STATUS_RIGHT  = 8'h02;
    localparam logic [BYTE_WIDTH-1:0] STATUS_MIDDLE = 8'h04;
    localparam logic [BYTE_WIDTH-1:0] STATUS_X_SIGN = 8'h10;
    localparam logic [BYTE_WIDTH-1:0] STATUS_Y_SIGN = 8'h20;

    // Position of the next byte within the packet stream
    typedef enum logic [1:0] {
        PHASE_ACK,
        PHASE_STATUS,
        PHASE_X_DELTA,
        PHASE_Y_DELTA
    } phase_t;

endpackage

FILE: src/ps2mct_axis.sv
// ----------------------------------------------------------------------------
// ps2mct_axis
// One cursor axis: adds a signed step to the position and clamps the sum
// to the range zero to the resolution, limited to the position width.
// ----------------------------------------------------------------------------
module ps2mct_axis
    import ps2mct_pkg::*;
#(
    parameter int POS_WIDTH = 12
)
(
    input  logic [POS_WIDTH-1:0]  pos,
    input  logic [STEP_WIDTH-1:0] step,
    input  logic [RES_WIDTH-1:0]  resolution,
    output logic [POS_WIDTH-1:0]  pos_next
);

    // Working width: room for the wider operand plus sign and carry
    localparam int CW = ((POS_WIDTH > RES_WIDTH) ? POS_WIDTH : RES_WIDTH) + 2;

    localparam logic [CW-1:0] POS_MAX = {{(CW-POS_WIDTH){1'b0}}, {POS_WIDTH{1'b1}}};

    logic [CW-1:0] sum;
    logic [CW-1:0] res_ext;
    logic [CW-1:0] top;
    logic [CW-1:0] clamped;

    // Add the sign-extended step to the zero-extended position
    assign sum = {{(CW-POS_WIDTH){1'b0}}, pos}
               + {{(CW-STEP_WIDTH){step[STEP_WIDTH-1]}}, step};

    // Limit the resolution to what the position register can hold
    assign res_ext = {{(CW-RES_WIDTH){1'b0}}, resolution};
    assign top     = (res_ext > POS_MAX) ? POS_MAX : res_ext;

    // Clamp below at zero and above at the limit
    always_comb
    begin
        if (sum[CW-1])
        begin
            clamped = '0;
        end
        else if (sum > top)
        begin
            clamped = top;
        end
        else
        begin
            clamped = sum;
        end
    end

    assign pos_next = clamped[POS_WIDTH-1:0];

endmodule

FILE: src/ps2_mouse_cursor_tracker.sv
// ----------------------------------------------------------------------------
// ps2_mouse_cursor_tracker
// Frames received PS/2 mouse bytes into packets and tracks a clamped cursor.
// ----------------------------------------------------------------------------
// The block takes one received byte per clock cycle while in_stall is low
// and produces one result per complete three-byte packet. The packet's last
// byte passes through the input register, then the packet decode and
// position update feed the result register, which raises out_valid when it
// loads. The first byte after reset is the enable acknowledge and is
// dropped. Deltas are 9-bit two's complement with the sign in status bits
// 4 and 5; the cursor moves by +dx and -dy and is clamped to 0..resolution
// on each axis. A resolution write applies from the next packet completion
// and does not re-clamp the held position.
// Stall on the result side holds the result register and backs up into the
// input register, then into in_stall.
module ps2_mouse_cursor_tracker
    import ps2mct_pkg::*;
#(
    parameter int POS_WIDTH = 12
)
(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [RES_WIDTH-1:0]       cfg_data,

    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [BYTE_WIDTH-1:0]      rx_byte,

    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       left_button,
    output logic                       right_button,
    output logic                       middle_button,
    output logic [COORD_WIDTH-1:0]     cursor_x,
    output logic [COORD_WIDTH-1:0]     cursor_y
);

    logic [RES_WIDTH-1:0]   x_res_reg;
    logic [RES_WIDTH-1:0]   y_res_reg;

    logic                   s1_valid_reg;
    logic [BYTE_WIDTH-1:0]  s1_byte_reg;
    logic                   s1_move;

    phase_t                 phase_reg;
    phase_t                 phase_next;
    logic [BYTE_WIDTH-1:0]  status_reg;
    logic [BYTE_WIDTH-1:0]  x_delta_reg;
    logic [POS_WIDTH-1:0]   pos_x_reg;
    logic [POS_WIDTH-1:0]   pos_y_reg;
    logic [POS_WIDTH-1:0]   pos_x_next;
    logic [POS_WIDTH-1:0]   pos_y_next;
    logic [STEP_WIDTH-1:0]  step_x;
    logic [STEP_WIDTH-1:0]  step_y;
    logic                   packet_done;

    logic                   out_valid_reg;
    logic                   left_reg;
    logic                   right_reg;
    logic                   middle_reg;
    logic [COORD_WIDTH-1:0] cursor_x_reg;
    logic [COORD_WIDTH-1:0] cursor_y_reg;

    // Capture resolution writes; ignore indexes beyond the register list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_res_reg <= X_RESOLUTION_RESET;
            y_res_reg <= Y_RESOLUTION_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_X_RESOLUTION: x_res_reg <= cfg_data;
                CFG_Y_RESOLUTION: y_res_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Advance the input register whenever the result register can take a value
    assign s1_move  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_move;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_byte_reg <= rx_byte;
        end
    end

    // Packet phase: drop the acknowledge, then cycle status, X, Y
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PHASE_ACK;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        packet_done = 1'b0;
        if (s1_move)
        begin
            unique case (phase_reg)
                PHASE_ACK:     phase_next = PHASE_STATUS;
                PHASE_STATUS:  phase_next = PHASE_X_DELTA;
                PHASE_X_DELTA: phase_next = PHASE_Y_DELTA;
                PHASE_Y_DELTA:
                begin
                    phase_next  = PHASE_STATUS;
                    packet_done = 1'b1;
                end
                default:       phase_next = PHASE_ACK;
            endcase
        end
    end

    // Hold the status and X delta bytes until the packet completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg  <= '0;
            x_delta_reg <= '0;
        end
        else if (s1_move)
        begin
            if (phase_reg == PHASE_STATUS)
            begin
                status_reg <= s1_byte_reg;
            end
            if (phase_reg == PHASE_X_DELTA)
            begin
                x_delta_reg <= s1_byte_reg;
            end
        end
    end

    // Form the steps: +dx horizontally, -dy vertically, from 9-bit signed deltas into 10-bit signed steps
    assign step_x = {{2{|(status_reg & STATUS_X_SIGN)}}, x_delta_reg};
    assign step_y = STEP_WIDTH'(0)
                  - {{2{|(status_reg & STATUS_Y_SIGN)}}, s1_byte_reg};

    ps2mct_axis #(
        .POS_WIDTH (POS_WIDTH)
    ) u_axis_x (
        .pos        (pos_x_reg),
        .step       (step_x),
        .resolution (x_res_reg),
        .pos_next   (pos_x_next)
    );

    ps2mct_axis #(
        .POS_WIDTH (POS_WIDTH)
    ) u_axis_y (
        .pos        (pos_y_reg),
        .step       (step_y),
        .resolution (y_res_reg),
        .pos_next   (pos_y_next)
    );

    // Update the position at the end of each packet
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
        end
        else if (packet_done)
        begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
        end
    end

    // Result register: load on packet completion, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (packet_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (packet_done)
        begin
            left_reg     <= |(status_reg & STATUS_LEFT);
            right_reg    <= |(status_reg & STATUS_RIGHT);
            middle_reg   <= |(status_reg & STATUS_MIDDLE);
            cursor_x_reg <= COORD_WIDTH'(pos_x_next);
            cursor_y_reg <= COORD_WIDTH'(pos_y_next);
        end
    end

    assign out_valid     = out_valid_reg;
    assign left_button   = left_reg;
    assign right_button  = right_reg;
    assign middle_button = middle_reg;
    assign cursor_x      = cursor_x_reg;
    assign cursor_y      = cursor_y_reg;

endmodule
